@@ hdl/tows_pkg.sv @@
// ----------------------------------------------------------------------------
// tows_pkg: shared types for the opening-window trajectory simplifier
// Beat formats, window entry layout, the control state machine and the
// step codes of the distance check sequencer.
// ----------------------------------------------------------------------------
package tows_pkg;

  // Default number of window slots, anchor included.
  localparam int WINDOW_DEPTH_DEF = 32;

  // Input beat: one trajectory point.
  typedef struct packed {
    logic signed [23:0] x_coord;
    logic signed [23:0] y_coord;
    logic        [23:0] time_stamp;
    logic               last_point;
  } in_beat_t;

  // Output beat: one kept point or the short-trajectory error.
  typedef struct packed {
    logic        [23:0] kept_index;
    logic signed [23:0] kept_x;
    logic signed [23:0] kept_y;
    logic        [23:0] kept_time;
    logic               last_kept;
    logic               too_short;
  } out_beat_t;

  // One stored window point.
  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic        [23:0] t;
    logic        [23:0] idx;
  } win_entry_t;

  // Point operand for the distance check.
  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic        [23:0] t;
  } pt_t;

  // Control state machine of the top level.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_START,
    ST_WAIT,
    ST_VIOL,
    ST_FULL,
    ST_WRITE,
    ST_LAST_ANCHOR,
    ST_LAST_END,
    ST_ERROR
  } tows_state_t;

  // Distance check steps; each but SS_DONE names the multiply issued in that cycle.
  typedef enum logic [3:0] {
    SS_XK,
    SS_XE,
    SS_YK,
    SS_YE,
    SS_RT,
    SS_XLL,
    SS_XLH,
    SS_XHH,
    SS_YLL,
    SS_YLH,
    SS_YHH,
    SS_RLL,
    SS_RLH,
    SS_RHH,
    SS_DONE
  } sed_step_t;

endpackage

@@ hdl/tows_win_mem.sv @@
// ----------------------------------------------------------------------------
// tows_win_mem: window point store
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module tows_win_mem #(
  parameter int WINDOW_DEPTH = tows_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [$clog2(WINDOW_DEPTH)-1:0] wr_addr,
  input  tows_pkg::win_entry_t            wr_data,
  input  logic [$clog2(WINDOW_DEPTH)-1:0] rd_addr,
  output tows_pkg::win_entry_t            rd_data
);
  import tows_pkg::*;

  win_entry_t mem [WINDOW_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/tows_sed_unit.sv @@
// ----------------------------------------------------------------------------
// tows_sed_unit: synchronized distance check
// Decides ex^2 + ey^2 > (threshold * dt)^2 exactly, using one shared
// 27x27 signed multiplier driven by a step sequencer. Wide squares are built
// from low and high halves and accumulated into a signed difference.
// ----------------------------------------------------------------------------
module tows_sed_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  tows_pkg::pt_t anc,
  input  tows_pkg::pt_t pnt,
  input  tows_pkg::pt_t fin,
  input  logic [23:0]   threshold,
  output logic          done,
  output logic          pt_out
);
  import tows_pkg::*;

  logic               busy;
  sed_step_t          step;
  sed_step_t          cur;
  logic               run;

  logic signed [24:0] dt;
  logic signed [24:0] dk;
  logic signed [24:0] dxk;
  logic signed [24:0] dxe;
  logic signed [24:0] dyk;
  logic signed [24:0] dye;
  logic        [24:0] dt_mag;

  logic signed [26:0] ma;
  logic signed [26:0] mb;
  logic signed [53:0] prod;
  logic signed [53:0] exr;
  logic signed [53:0] eyr;
  logic signed [53:0] diff;
  logic        [53:0] diff_mag;
  logic        [50:0] magx;
  logic        [50:0] magy;
  logic        [50:0] magr;
  logic signed [103:0] acc;
  logic signed [103:0] prod_ext;
  logic signed [103:0] acc_fin;

  // Coordinate and time differences against the anchor.
  always_comb begin
    dt     = $signed({1'b0, fin.t}) - $signed({1'b0, anc.t});
    dk     = $signed({1'b0, pnt.t}) - $signed({1'b0, anc.t});
    dxk    = $signed({pnt.x[23], pnt.x}) - $signed({anc.x[23], anc.x});
    dxe    = $signed({fin.x[23], fin.x}) - $signed({anc.x[23], anc.x});
    dyk    = $signed({pnt.y[23], pnt.y}) - $signed({anc.y[23], anc.y});
    dye    = $signed({fin.y[23], fin.y}) - $signed({anc.y[23], anc.y});
    dt_mag = dt[24] ? 25'(-dt) : 25'(dt);
  end

  assign cur  = busy ? step : SS_XK;
  assign run  = busy || start;
  assign diff = exr - prod;
  assign diff_mag = diff[53] ? 54'(-diff) : 54'(diff);
  assign prod_ext = {{50{prod[53]}}, prod};

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cur)
      SS_XK: begin
        ma = {{2{dxk[24]}}, dxk};
        mb = {{2{dt[24]}}, dt};
      end
      SS_XE: begin
        ma = {{2{dxe[24]}}, dxe};
        mb = {{2{dk[24]}}, dk};
      end
      SS_YK: begin
        ma = {{2{dyk[24]}}, dyk};
        mb = {{2{dt[24]}}, dt};
      end
      SS_YE: begin
        ma = {{2{dye[24]}}, dye};
        mb = {{2{dk[24]}}, dk};
      end
      SS_RT: begin
        ma = {3'b000, threshold};
        mb = {2'b00, dt_mag};
      end
      SS_XLL: begin
        ma = {1'b0, magx[25:0]};
        mb = {1'b0, magx[25:0]};
      end
      SS_XLH: begin
        ma = {1'b0, magx[25:0]};
        mb = {2'b00, magx[50:26]};
      end
      SS_XHH: begin
        ma = {2'b00, magx[50:26]};
        mb = {2'b00, magx[50:26]};
      end
      SS_YLL: begin
        ma = {1'b0, magy[25:0]};
        mb = {1'b0, magy[25:0]};
      end
      SS_YLH: begin
        ma = {1'b0, magy[25:0]};
        mb = {2'b00, magy[50:26]};
      end
      SS_YHH: begin
        ma = {2'b00, magy[50:26]};
        mb = {2'b00, magy[50:26]};
      end
      SS_RLL: begin
        ma = {1'b0, magr[25:0]};
        mb = {1'b0, magr[25:0]};
      end
      SS_RLH: begin
        ma = {1'b0, magr[25:0]};
        mb = {2'b00, magr[50:26]};
      end
      SS_RHH: begin
        ma = {2'b00, magr[50:26]};
        mb = {2'b00, magr[50:26]};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= SS_XK;
    end else if (run) begin
      if (cur == SS_DONE) begin
        busy <= 1'b0;
        step <= SS_XK;
      end else begin
        busy <= 1'b1;
        step <= sed_step_t'(4'(cur) + 4'd1);
      end
    end
  end

  // Multiplier register and accumulation of the previous product.
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (run) begin
      case (cur)
        SS_XE:  exr  <= prod;
        SS_YK:  magx <= diff_mag[50:0];
        SS_YE:  eyr  <= prod;
        SS_RT:  magy <= 51'(eyr - prod < 0 ? -(eyr - prod) : (eyr - prod));
        SS_XLL: magr <= prod[50:0];
        SS_XLH: acc  <= prod_ext;
        SS_XHH: acc  <= acc + (prod_ext <<< 27);
        SS_YLL: acc  <= acc + (prod_ext <<< 52);
        SS_YLH: acc  <= acc + prod_ext;
        SS_YHH: acc  <= acc + (prod_ext <<< 27);
        SS_RLL: acc  <= acc + (prod_ext <<< 52);
        SS_RLH: acc  <= acc - prod_ext;
        SS_RHH: acc  <= acc - (prod_ext <<< 27);
        default: ;
      endcase
    end
  end

  // Final subtraction and decision in the last step.
  assign acc_fin = acc - (prod_ext <<< 52);
  assign done    = busy && (step == SS_DONE);
  assign pt_out  = !acc_fin[103] && (acc_fin != '0);

endmodule

@@ hdl/trajectory_opening_window_simplifier.sv @@
// ----------------------------------------------------------------------------
// trajectory_opening_window_simplifier: opening-window trajectory simplifier
// Keeps the points since the anchor in a window store and rechecks each
// against the anchor-to-end line on every new point, emitting kept points.
// ----------------------------------------------------------------------------
// Each accepted point is checked in turn against every held point after the
// anchor; a check is the scan, load, start and wait states, the distance unit
// running its 15 steps. After a violation the later points are rechecked.
// One item at a time: input stalls until a point is done; results leave through a one-beat register.
// Reset clears the window and point counter and sets threshold to 1; the
// window store needs no clearing pass.
// ----------------------------------------------------------------------------
module trajectory_opening_window_simplifier #(
  parameter int WINDOW_DEPTH = tows_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tows_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tows_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [23:0]         cfg_data
);
  import tows_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);

  tows_state_t state;
  tows_state_t state_next;

  logic [23:0]   threshold;
  logic [AW-1:0] head;
  logic [FW-1:0] fill;
  logic [23:0]   point_counter;
  logic [FW-1:0] ofs;
  logic [AW-1:0] slot_cur;
  logic [AW-1:0] slot_inc;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] prev_slot;
  logic [AW-1:0] wr_slot;
  logic [AW:0]   wr_sum;
  win_entry_t    e_ent;
  logic          e_last;
  win_entry_t    anc;
  win_entry_t    prv;
  win_entry_t    rd_data;
  logic          wr_en;
  pt_t           anc_pt;
  pt_t           pnt_pt;
  pt_t           fin_pt;

  logic          out_free;
  logic          emit;
  out_beat_t     emit_beat;
  out_beat_t     anc_beat;
  logic          dt_zero;
  logic          win_full;
  logic          sed_start;
  logic          sed_done;
  logic          sed_out;

  // Slot pointer arithmetic with wrap at the window depth.
  assign slot_inc = (slot_cur == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_cur + 1'b1;
  assign head_inc = (head == AW'(WINDOW_DEPTH - 1)) ? '0 : head + 1'b1;
  assign wr_sum   = (AW + 1)'(head) + (AW + 1)'(fill);
  assign wr_slot  = (wr_sum >= (AW + 1)'(WINDOW_DEPTH)) ?
                    AW'(wr_sum - (AW + 1)'(WINDOW_DEPTH)) : AW'(wr_sum);

  assign out_free = !out_valid || !out_stall;
  assign dt_zero  = (e_ent.t == anc.t);
  assign win_full = (fill == FW'(WINDOW_DEPTH));
  assign in_stall = (state != ST_IDLE);
  assign wr_en    = (state == ST_WRITE);
  assign anc_beat = '{kept_index: anc.idx, kept_x: anc.x, kept_y: anc.y,
                      kept_time: anc.t, last_kept: 1'b0, too_short: 1'b0};

  // Operands of the distance check.
  assign anc_pt = '{x: anc.x, y: anc.y, t: anc.t};
  assign pnt_pt = '{x: rd_data.x, y: rd_data.y, t: rd_data.t};
  assign fin_pt = '{x: e_ent.x, y: e_ent.y, t: e_ent.t};

  // Window store.
  tows_win_mem #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_slot),
    .wr_data(e_ent),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Distance check of the point read from the store.
  tows_sed_unit u_sed (
    .clk      (clk),
    .rst      (rst),
    .start    (sed_start),
    .anc      (anc_pt),
    .pnt      (pnt_pt),
    .fin      (fin_pt),
    .threshold(threshold),
    .done     (sed_done),
    .pt_out   (sed_out)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and result selection.
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_beat  = anc_beat;
    sed_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.last_point && (fill < FW'(2))) begin
            state_next = ST_ERROR;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        state_next = ((ofs >= fill) || dt_zero) ? ST_FULL : ST_LOAD;
      end
      ST_LOAD: begin
        state_next = ST_START;
      end
      ST_START: begin
        sed_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (sed_done) begin
          state_next = sed_out ? ST_VIOL : ST_SCAN;
        end
      end
      ST_VIOL: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_FULL: begin
        if (!win_full) begin
          state_next = ST_WRITE;
        end else if (out_free) begin
          emit       = 1'b1;
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_next = e_last ? ST_LAST_ANCHOR : ST_IDLE;
      end
      ST_LAST_ANCHOR: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_LAST_END;
        end
      end
      ST_LAST_END: begin
        emit_beat = '{kept_index: e_ent.idx, kept_x: e_ent.x, kept_y: e_ent.y,
                      kept_time: e_ent.t, last_kept: 1'b1, too_short: 1'b0};
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_ERROR: begin
        emit_beat = '{kept_index: '0, kept_x: '0, kept_y: '0, kept_time: '0,
                      last_kept: 1'b1, too_short: 1'b1};
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Window bookkeeping, anchor and end point registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      fill          <= '0;
      point_counter <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            e_ent         <= '{x: in_data.x_coord, y: in_data.y_coord,
                               t: in_data.time_stamp, idx: point_counter};
            e_last        <= in_data.last_point;
            point_counter <= point_counter + 24'd1;
            ofs           <= FW'(1);
            slot_cur      <= head_inc;
          end
        end
        ST_SCAN: begin
          rd_addr <= slot_cur;
        end
        ST_WAIT: begin
          if (sed_done && !sed_out) begin
            ofs      <= ofs + 1'b1;
            slot_cur <= slot_inc;
          end
        end
        ST_VIOL: begin
          // The violating point becomes the anchor; rescan from its successor.
          if (out_free) begin
            anc      <= rd_data;
            head     <= slot_cur;
            fill     <= fill - ofs;
            ofs      <= FW'(1);
            slot_cur <= slot_inc;
          end
        end
        ST_FULL: begin
          // A full window moves the anchor to the newest held point.
          if (win_full && out_free) begin
            anc  <= prv;
            head <= prev_slot;
            fill <= FW'(1);
          end
        end
        ST_WRITE: begin
          prv       <= e_ent;
          prev_slot <= wr_slot;
          fill      <= fill + 1'b1;
          if (fill == '0) begin
            anc <= e_ent;
          end
        end
        ST_LAST_END, ST_ERROR: begin
          if (out_free) begin
            head          <= '0;
            fill          <= '0;
            point_counter <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 24'd1;
    end else if (cfg_we) begin
      threshold <= cfg_data;
    end
  end

  // Output register: holds one beat until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= emit_beat;
    end
  end

  // The window never holds more points than it has slots.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(WINDOW_DEPTH))
    else $error("window fill exceeds depth");

  // The check unit only finishes while the control waits for it.
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    sed_done |-> state == ST_WAIT)
    else $error("distance check finished outside wait state");

  // A violation always shrinks the window.
  a_viol_shrink: assert property (@(posedge clk) disable iff (rst)
    (state == ST_VIOL && out_free) |=> fill < $past(fill))
    else $error("violation did not shrink the window");

  // After the final beat of a trajectory the window is empty.
  a_end_clear: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_LAST_END || state == ST_ERROR) && out_free) |=> fill == '0)
    else $error("window not cleared at trajectory end");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the opening-window trajectory simplifier
// A queue of trajectory points feeds a clocked driver; a clocked monitor
// compares each kept-point beat with a predictor that mirrors the window
// logic with exact integer arithmetic. Threshold is changed between phases.
// ----------------------------------------------------------------------------
module testbench;
  import tows_pkg::*;

  localparam int DEPTH = 32;
  localparam int MAX_CYCLES = 2000000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  out_beat_t out_data;
  logic cfg_we;
  logic [23:0] cfg_data;

  // Predictor state.
  logic [23:0] thr_model;
  win_entry_t win_store [DEPTH];
  int unsigned win_head;
  int unsigned win_fill;
  logic [23:0] point_count;

  in_beat_t point_queue[$];
  out_beat_t kept_queue[$];
  int errors;
  int accepted;
  int pushed;
  bit hold_rx;
  int rx_hold_cycles;
  longint cycle_count;
  bit tx_taken;

  trajectory_opening_window_simplifier #(.WINDOW_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // True when window slot k lies too far from the anchor-to-end line.
  function automatic bit deviates(int unsigned k, logic signed [23:0] xe,
                                  logic signed [23:0] ye, logic [23:0] te);
    win_entry_t a;
    win_entry_t p;
    logic signed [63:0] dt;
    logic signed [63:0] dk;
    logic signed [63:0] ex;
    logic signed [63:0] ey;
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [127:0] m;
    a = win_store[win_head % DEPTH];
    p = win_store[k];
    dt = $signed({40'd0, te}) - $signed({40'd0, a.t});
    dk = $signed({40'd0, p.t}) - $signed({40'd0, a.t});
    if (dt == 0) return 1'b0;
    ex = (64'(p.x) - 64'(a.x)) * dt - (64'(xe) - 64'(a.x)) * dk;
    ey = (64'(p.y) - 64'(a.y)) * dt - (64'(ye) - 64'(a.y)) * dk;
    if (ex < 0) ex = -ex;
    if (ey < 0) ey = -ey;
    if (dt < 0) dt = -dt;
    lhs = 128'(ex) * 128'(ex) + 128'(ey) * 128'(ey);
    m = 128'(thr_model) * 128'(dt);
    rhs = m * m;
    return lhs > rhs;
  endfunction

  function automatic void push_anchor();
    win_entry_t a;
    out_beat_t r;
    a = win_store[win_head % DEPTH];
    r = '{kept_index: a.idx, kept_x: a.x, kept_y: a.y, kept_time: a.t,
          last_kept: 1'b0, too_short: 1'b0};
    kept_queue.push_back(r);
  endfunction

  // Expected kept points for one accepted trajectory point.
  function automatic void predict_point(in_beat_t p);
    logic [23:0] idx;
    bit again;
    int unsigned s;
    out_beat_t r;
    idx = point_count;
    point_count = point_count + 24'd1;
    if (p.last_point && win_fill < 2) begin
      r = '{kept_index: 24'd0, kept_x: 24'sd0, kept_y: 24'sd0, kept_time: 24'd0,
            last_kept: 1'b1, too_short: 1'b1};
      kept_queue.push_back(r);
      win_head = 0; win_fill = 0; point_count = '0;
      return;
    end
    do begin
      again = 1'b0;
      for (int unsigned i = 1; i < win_fill; i++) begin
        s = (win_head + i) % DEPTH;
        if (deviates(s, p.x_coord, p.y_coord, p.time_stamp)) begin
          push_anchor();
          win_head = s;
          win_fill -= i;
          again = 1'b1;
          break;
        end
      end
    end while (again);
    if (win_fill >= DEPTH) begin
      push_anchor();
      win_head = (win_head + win_fill - 1) % DEPTH;
      win_fill = 1;
    end
    s = (win_head + win_fill) % DEPTH;
    win_store[s] = '{x: p.x_coord, y: p.y_coord, t: p.time_stamp, idx: idx};
    win_fill++;
    if (p.last_point) begin
      push_anchor();
      r = '{kept_index: idx, kept_x: p.x_coord, kept_y: p.y_coord,
            kept_time: p.time_stamp, last_kept: 1'b1, too_short: 1'b0};
      kept_queue.push_back(r);
      win_head = 0; win_fill = 0; point_count = '0;
    end
  endfunction

  // Driver: offers queued points with random gaps.
  int tx_gap;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else if (in_valid && !tx_taken) begin
      // payload held until taken
    end else if (tx_gap > 0) begin
      in_valid <= 1'b0;
      tx_gap <= tx_gap - 1;
    end else if (point_queue.size() > 0) begin
      in_valid <= 1'b1;
      in_data <= point_queue.pop_front();
      tx_gap <= $urandom_range(0, 3);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Track acceptance at the rising edge and update the predictor.
  always @(posedge clk) begin
    tx_taken = !rst && in_valid && !in_stall;
    if (tx_taken) begin
      predict_point(in_data);
      accepted++;
    end
  end

  // Receiver stall: random per beat, or a long hold-off when asked.
  int rx_gap;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_gap <= 0;
    end else if (rx_hold_cycles > 0) begin
      out_stall <= 1'b1;
      rx_hold_cycles <= rx_hold_cycles - 1;
    end else if (hold_rx) begin
      out_stall <= 1'b1;
      rx_hold_cycles <= 400;
      hold_rx <= 1'b0;
    end else if (rx_gap > 0) begin
      out_stall <= 1'b1;
      rx_gap <= rx_gap - 1;
    end else begin
      out_stall <= 1'b0;
      rx_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
    end
  end

  // Monitor: compare each kept-point beat with the oldest expectation.
  always @(posedge clk) begin
    out_beat_t e;
    if (!rst && out_valid && !out_stall) begin
      if (kept_queue.size() == 0) begin
        $error("unexpected beat index=%0d", out_data.kept_index);
        errors++;
      end else begin
        e = kept_queue.pop_front();
        if (out_data.kept_index !== e.kept_index) begin
          $error("kept_index exp %0d got %0d", e.kept_index, out_data.kept_index);
          errors++;
        end
        if (out_data.kept_x !== e.kept_x) begin
          $error("kept_x exp %0d got %0d", e.kept_x, out_data.kept_x);
          errors++;
        end
        if (out_data.kept_y !== e.kept_y) begin
          $error("kept_y exp %0d got %0d", e.kept_y, out_data.kept_y);
          errors++;
        end
        if (out_data.kept_time !== e.kept_time) begin
          $error("kept_time exp %0d got %0d", e.kept_time, out_data.kept_time);
          errors++;
        end
        if (out_data.last_kept !== e.last_kept) begin
          $error("last_kept exp %0d got %0d", e.last_kept, out_data.last_kept);
          errors++;
        end
        if (out_data.too_short !== e.too_short) begin
          $error("too_short exp %0d got %0d", e.too_short, out_data.too_short);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_point(logic signed [23:0] x, logic signed [23:0] y,
                           logic [23:0] t, logic last);
    in_beat_t p;
    p = '{x_coord: x, y_coord: y, time_stamp: t, last_point: last};
    point_queue.push_back(p);
    pushed++;
  endtask

  // Wait until all queued points are taken and every kept point has arrived.
  task automatic drain();
    while (point_queue.size() > 0 || accepted < pushed || kept_queue.size() > 0 ||
           in_valid)
      @(posedge clk);
    repeat (40 * DEPTH) @(posedge clk);
  endtask

  task automatic set_threshold(logic [23:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    thr_model = v;
  endtask

  // A random trajectory: a drifting walk with occasional jumps and equal times.
  task automatic random_track(int n, int unsigned jitter);
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [23:0] t;
    x = 24'($urandom); y = 24'($urandom); t = 24'($urandom_range(0, 1000));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          x = 24'($urandom); y = 24'($urandom);
        end
        1: ;
        default: begin
          x = x + $signed(24'($urandom_range(0, 2 * jitter))) - 24'(jitter);
          y = y + $signed(24'($urandom_range(0, 2 * jitter))) - 24'(jitter);
        end
      endcase
      if ($urandom_range(0, 7) != 0) t = t + 24'($urandom_range(0, 20));
      add_point(x, y, t, i == n - 1);
    end
  endtask

  initial begin
    int n;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    errors = 0; accepted = 0; pushed = 0;
    hold_rx = 1'b0; rx_hold_cycles = 0; cycle_count = 0;
    thr_model = 24'd1;
    win_head = 0; win_fill = 0; point_count = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: short trajectories (one and zero held points) at reset threshold.
    add_point(24'sd5, -24'sd5, 24'd10, 1'b1);
    add_point(24'sh7FFFFF, 24'sh800000, 24'hFFFFFF, 1'b0);
    add_point(24'sh800000, 24'sh7FFFFF, 24'd0, 1'b1);
    // Equal timestamps never break; out-of-order time; extreme coordinates.
    add_point(24'sd0, 24'sd0, 24'd100, 1'b0);
    add_point(24'sh7FFFFF, 24'sh7FFFFF, 24'd100, 1'b0);
    add_point(24'sh800000, 24'sd3, 24'd100, 1'b0);
    add_point(24'sd9, 24'sd9, 24'd50, 1'b0);
    add_point(24'sh800000, 24'sh800000, 24'hFFFFFF, 1'b0);
    add_point(24'sd1, 24'sd1, 24'hFFFFFF, 1'b1);
    drain();

    // Maximum threshold, a straight line, and a full window.
    set_threshold(24'hFFFFFF);
    for (int i = 0; i < 40; i++) add_point(24'(i), -24'(i), 24'(i), i == 39);
    drain();

    // Threshold zero: any deviation breaks.
    set_threshold(24'd0);
    add_point(24'sd0, 24'sd0, 24'd0, 1'b0);
    add_point(24'sd1, 24'sd0, 24'd1, 1'b0);
    add_point(24'sd0, 24'sd0, 24'd2, 1'b0);
    add_point(24'sd5, 24'sd5, 24'd3, 1'b1);
    drain();

    // Back-pressure: long receiver hold while the sender keeps offering.
    set_threshold(24'd3);
    hold_rx = 1'b1;
    random_track(30, 50);
    drain();

    // Random phases with various thresholds.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_threshold(24'd1);
        1: set_threshold(24'd40);
        2: set_threshold(24'($urandom_range(1, 24'hFFFFFF)));
        default: set_threshold(24'd1000);
      endcase
      for (int k = 0; k < 5; k++) begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 14);
        random_track(n, (k % 2) ? 100000 : 30);
      end
      // Sender pauses until everything has come back.
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
